/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TDP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define TDP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/tdp_pkg.sv */
package tdp_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int DUTY_W     = 7;
    localparam int PROD_W     = DUTY_W + MS_W;
    localparam int PHASE_W    = 3;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // bits of elapsed time handled per cycle by the boundary scan
    localparam int SCAN_DIGIT_W = 4;

    localparam logic [MS_W-1:0]   RAMP_UP_RST     = 16'd1500;
    localparam logic [MS_W-1:0]   CRUISE_RST      = 16'd2000;
    localparam logic [MS_W-1:0]   RAMP_DN_RST     = 16'd1500;
    localparam logic [DUTY_W-1:0] CRUISE_DUTY_RST = 7'd22;
    localparam logic [DUTY_W-1:0] DUTY_MAX        = 7'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_ARM   = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } tdp_cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_DISARMED  = 3'd0,
        PH_READY     = 3'd1,
        PH_RAMP_UP   = 3'd2,
        PH_CRUISE    = 3'd3,
        PH_RAMP_DOWN = 3'd4,
        PH_STOPPED   = 3'd5
    } tdp_phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_UP     = 2'd0,
        CFG_CRUISE      = 2'd1,
        CFG_RAMP_DN     = 2'd2,
        CFG_CRUISE_DUTY = 2'd3
    } tdp_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MULDIV,
        ST_DONE
    } tdp_state_t;

    typedef struct packed {
        logic [MS_W-1:0] ramp_up;
        logic [MS_W-1:0] cruise;
        logic [MS_W-1:0] ramp_dn;
    } tdp_spans_t;

    // boundary scan result; flags are unsigned elapsed < boundary
    typedef struct packed {
        logic            done;
        logic            lt_up;
        logic            lt_cruise;
        logic            lt_end;
        logic [MS_W-1:0] t_up;
        logic [MS_W-1:0] t_dn;
    } tdp_bound_res_t;

endpackage

/* rtl/tdp_if.sv */
interface tdp_req_if import tdp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output cmd, output now_ms, input ready);
    modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface tdp_rsp_if import tdp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic [DUTY_W-1:0]  duty_percent;
    logic               drive_enabled;
    logic               just_stopped;
    logic               start_accepted;

    modport source (output valid, output phase, output duty_percent, output drive_enabled,
                    output just_stopped, output start_accepted, input ready);
    modport sink   (input valid, input phase, input duty_percent, input drive_enabled,
                    input just_stopped, input start_accepted, output ready);
endinterface

/* rtl/tdp_bound.sv */
// Digit-serial elapsed time and boundary compare, LSB digit first.
module tdp_bound import tdp_pkg::*; #(
    parameter int DIGIT_W = SCAN_DIGIT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] start_time,
    input  tdp_spans_t        spans,
    output tdp_bound_res_t    res
);

    localparam int NDIG = TIME_W / DIGIT_W;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NDIG - 1);

    logic [TIME_W-1:0] now_sh_reg, st_sh_reg, up_sh_reg, cr_sh_reg, dn_sh_reg;
    logic [TIME_W-1:0] el_sh_reg, rel_sh_reg;
    logic              br_e_reg, br_up_reg, br_cr_reg, br_end_reg, cy_b2_reg, cy_b3_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIGIT_W:0]  e_x, b2_x, b3_x, up_x, cr_x, end_x;

    always_comb
    begin
        e_x   = {1'b0, now_sh_reg[DIGIT_W-1:0]} - {1'b0, st_sh_reg[DIGIT_W-1:0]}
              - (DIGIT_W+1)'(br_e_reg);
        b2_x  = {1'b0, up_sh_reg[DIGIT_W-1:0]} + {1'b0, cr_sh_reg[DIGIT_W-1:0]}
              + (DIGIT_W+1)'(cy_b2_reg);
        b3_x  = {1'b0, b2_x[DIGIT_W-1:0]} + {1'b0, dn_sh_reg[DIGIT_W-1:0]}
              + (DIGIT_W+1)'(cy_b3_reg);
        up_x  = {1'b0, e_x[DIGIT_W-1:0]} - {1'b0, up_sh_reg[DIGIT_W-1:0]}
              - (DIGIT_W+1)'(br_up_reg);
        cr_x  = {1'b0, e_x[DIGIT_W-1:0]} - {1'b0, b2_x[DIGIT_W-1:0]}
              - (DIGIT_W+1)'(br_cr_reg);
        end_x = {1'b0, e_x[DIGIT_W-1:0]} - {1'b0, b3_x[DIGIT_W-1:0]}
              - (DIGIT_W+1)'(br_end_reg);
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            now_sh_reg <= now_ms;
            st_sh_reg  <= start_time;
            up_sh_reg  <= TIME_W'(spans.ramp_up);
            cr_sh_reg  <= TIME_W'(spans.cruise);
            dn_sh_reg  <= TIME_W'(spans.ramp_dn);
            br_e_reg   <= 1'b0;
            br_up_reg  <= 1'b0;
            br_cr_reg  <= 1'b0;
            br_end_reg <= 1'b0;
            cy_b2_reg  <= 1'b0;
            cy_b3_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            now_sh_reg <= now_sh_reg >> DIGIT_W;
            st_sh_reg  <= st_sh_reg >> DIGIT_W;
            up_sh_reg  <= up_sh_reg >> DIGIT_W;
            cr_sh_reg  <= cr_sh_reg >> DIGIT_W;
            dn_sh_reg  <= dn_sh_reg >> DIGIT_W;
            el_sh_reg  <= {e_x[DIGIT_W-1:0], el_sh_reg[TIME_W-1:DIGIT_W]};
            rel_sh_reg <= {cr_x[DIGIT_W-1:0], rel_sh_reg[TIME_W-1:DIGIT_W]};
            br_e_reg   <= e_x[DIGIT_W];
            br_up_reg  <= up_x[DIGIT_W];
            br_cr_reg  <= cr_x[DIGIT_W];
            br_end_reg <= end_x[DIGIT_W];
            cy_b2_reg  <= b2_x[DIGIT_W];
            cy_b3_reg  <= b3_x[DIGIT_W];
        end
    end

    assign res.done      = done_reg;
    assign res.lt_up     = br_up_reg;
    assign res.lt_cruise = br_cr_reg;
    assign res.lt_end    = br_end_reg;
    assign res.t_up      = el_sh_reg[MS_W-1:0];
    assign res.t_dn      = rel_sh_reg[MS_W-1:0];

endmodule

/* rtl/tdp_muldiv.sv */
// Shift-add multiply (one duty bit a cycle), then restoring divide
// (one quotient bit a cycle). Quotient is known to fit DUTY_W bits.
module tdp_muldiv import tdp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DUTY_W-1:0] cd,
    input  logic [MS_W-1:0]   t,
    input  logic [MS_W-1:0]   dv,
    output logic              done,
    output logic [DUTY_W-1:0] q
);

    localparam int CNT_W = $clog2(DUTY_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DUTY_W - 1);

    logic [DUTY_W-1:0] cd_sh_reg, q_reg;
    logic [PROD_W-1:0] mc_reg, acc_reg, dsh_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              div_reg, div_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = (acc_reg >= dsh_reg);

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            div_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                cnt_next = '0;
                if (div_reg)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    div_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cd_sh_reg <= cd;
            mc_reg    <= PROD_W'(t);
            acc_reg   <= '0;
            dsh_reg   <= PROD_W'({dv, {(DUTY_W-1){1'b0}}});
            q_reg     <= '0;
        end
        else if (busy_reg && !div_reg)
        begin
            if (cd_sh_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg    <= mc_reg << 1;
            cd_sh_reg <= cd_sh_reg >> 1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                acc_reg <= acc_reg - dsh_reg;
            end
            q_reg   <= {q_reg[DUTY_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* rtl/trapezoid_duty_profile.sv */
// Trapezoidal duty profile sequencer. Each request beat carries a command
// (tick, arm, start, stop) and the millisecond time; each yields exactly one
// response beat with the phase after the command, the duty, drive enable,
// end-of-profile and start-accepted flags. Arm, start, stop and ticks outside
// an active phase settle at once, with no scan. A tick in ramp up, cruise or
// ramp down first runs the boundary scan, which works out elapsed time and
// compares it with the three cumulative boundaries DIGIT_W bits a cycle; a
// tick that lands in cruise or past the end then needs no multiply or
// divide. A tick on a ramp adds the serial multiply and divide. DIGIT_W
// must divide 32 and be at most 16. The response sits in an output register,
// so a new request is taken while the last response waits. Configuration
// writes are meant for idle periods only.
`include "assert_macros.svh"

module trapezoid_duty_profile import tdp_pkg::*; #(
    parameter int DIGIT_W = SCAN_DIGIT_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tdp_req_if.sink               req,
    tdp_rsp_if.source             rsp
);

    // configuration
    logic [MS_W-1:0]   ramp_up_reg, cruise_reg, ramp_dn_reg;
    logic [DUTY_W-1:0] cd_reg;
    logic [DUTY_W-1:0] cfg_duty;

    // profile state
    tdp_phase_t        phase_reg;
    logic [TIME_W-1:0] start_time_reg;
    tdp_state_t        state_reg, state_next;

    // result being built for the current beat
    tdp_phase_t        res_phase_reg;
    logic [DUTY_W-1:0] res_duty_reg;
    logic              res_ended_reg;
    logic              res_acc_reg;

    // output register
    logic               out_valid_reg;
    logic [PHASE_W-1:0] out_phase_reg;
    logic [DUTY_W-1:0]  out_duty_reg;
    logic               out_drive_reg;
    logic               out_ended_reg;
    logic               out_acc_reg;

    logic              req_fire;
    tdp_cmd_t          req_cmd;
    logic              active;
    logic              scan_go;
    tdp_phase_t        dir_phase;
    logic              dir_acc;
    logic              on_ramp;
    logic              md_go;
    logic              out_load;
    tdp_spans_t        spans;
    tdp_bound_res_t    bnd;
    logic              md_done;
    logic [DUTY_W-1:0] md_q;

    assign req_cmd  = tdp_cmd_t'(req.cmd);
    assign req_fire = req.valid && req.ready;
    assign active   = phase_reg inside {PH_RAMP_UP, PH_CRUISE, PH_RAMP_DOWN};
    assign scan_go  = req_fire && (req_cmd == CMD_TICK) && active;
    // ramp up, or past cruise but before the end
    assign on_ramp  = bnd.lt_up || (bnd.lt_end && !bnd.lt_cruise);

    assign spans.ramp_up = ramp_up_reg;
    assign spans.cruise  = cruise_reg;
    assign spans.ramp_dn = ramp_dn_reg;

    // Commands that settle at once: arm, start, stop, idle-phase tick.
    always_comb
    begin
        dir_phase = phase_reg;
        dir_acc   = 1'b0;
        unique case (req_cmd)
            CMD_TICK:
            begin
                dir_phase = phase_reg;
            end
            CMD_ARM:
            begin
                if (phase_reg == PH_DISARMED || phase_reg == PH_STOPPED)
                begin
                    dir_phase = PH_READY;
                end
            end
            CMD_START:
            begin
                if (phase_reg == PH_READY)
                begin
                    dir_phase = PH_RAMP_UP;
                    dir_acc   = 1'b1;
                end
            end
            CMD_STOP:
            begin
                dir_phase = PH_STOPPED;
            end
        endcase
    end

    // configuration writes; cruise duty saturates at DUTY_MAX (100 percent)
    assign cfg_duty = cfg_wdata[DUTY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_up_reg <= RAMP_UP_RST;
            cruise_reg  <= CRUISE_RST;
            ramp_dn_reg <= RAMP_DN_RST;
            cd_reg      <= CRUISE_DUTY_RST;
        end
        else if (cfg_we)
        begin
            unique case (tdp_cfg_idx_t'(cfg_index))
                CFG_RAMP_UP:     ramp_up_reg <= cfg_wdata[MS_W-1:0];
                CFG_CRUISE:      cruise_reg  <= cfg_wdata[MS_W-1:0];
                CFG_RAMP_DN:     ramp_dn_reg <= cfg_wdata[MS_W-1:0];
                CFG_CRUISE_DUTY: cd_reg      <= (cfg_duty > DUTY_MAX) ? DUTY_MAX : cfg_duty;
            endcase
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = scan_go ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (bnd.done)
                begin
                    state_next = on_ramp ? ST_MULDIV : ST_DONE;
                end
            end
            ST_MULDIV:
            begin
                if (md_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        req.ready = 1'b0;
        md_go     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_SCAN:   md_go     = bnd.done && on_ramp;
            ST_MULDIV: md_go     = 1'b0;
            ST_DONE:   out_load  = !out_valid_reg || rsp.ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_DISARMED;
            start_time_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire && dir_acc)
            begin
                start_time_reg <= req.now_ms;
            end
            // phase commits as the beat's result is handed on
            if (out_load)
            begin
                phase_reg <= res_phase_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result build-up
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_phase_reg <= dir_phase;
            res_duty_reg  <= '0;
            res_ended_reg <= 1'b0;
            res_acc_reg   <= dir_acc;
        end
        else if (state_reg == ST_SCAN && bnd.done)
        begin
            if (!bnd.lt_end)
            begin
                res_phase_reg <= PH_STOPPED;
                res_ended_reg <= 1'b1;
            end
            else if (bnd.lt_up)
            begin
                res_phase_reg <= PH_RAMP_UP;
            end
            else if (bnd.lt_cruise)
            begin
                res_phase_reg <= PH_CRUISE;
                res_duty_reg  <= cd_reg;
            end
            else
            begin
                res_phase_reg <= PH_RAMP_DOWN;
            end
        end
        else if (state_reg == ST_MULDIV && md_done)
        begin
            // ramp down mirrors the rise: cruise level less the scaled part
            res_duty_reg <= bnd.lt_up ? md_q : (cd_reg - md_q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_phase_reg <= res_phase_reg;
            out_duty_reg  <= res_duty_reg;
            out_drive_reg <= (res_duty_reg != '0);
            out_ended_reg <= res_ended_reg;
            out_acc_reg   <= res_acc_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.phase          = out_phase_reg;
    assign rsp.duty_percent   = out_duty_reg;
    assign rsp.drive_enabled  = out_drive_reg;
    assign rsp.just_stopped   = out_ended_reg;
    assign rsp.start_accepted = out_acc_reg;

    tdp_bound #(
        .DIGIT_W (DIGIT_W)
    ) u_bound (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_go),
        .now_ms     (req.now_ms),
        .start_time (start_time_reg),
        .spans      (spans),
        .res        (bnd)
    );

    tdp_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_go),
        .cd    (cd_reg),
        .t     (bnd.lt_up ? bnd.t_up : bnd.t_dn),
        .dv    (bnd.lt_up ? ramp_up_reg : ramp_dn_reg),
        .done  (md_done),
        .q     (md_q)
    );

    `TDP_ASSERT_IMPL(a_scan_done_in_scan, bnd.done, state_reg == ST_SCAN)
    `TDP_ASSERT_IMPL(a_md_done_in_muldiv, md_done, state_reg == ST_MULDIV)
    `TDP_ASSERT_IMPL(a_duty_within_cruise, state_reg == ST_DONE, res_duty_reg <= cd_reg)
    `TDP_ASSERT_NEXT(a_phase_only_on_load, !out_load, $stable(phase_reg))

endmodule
